// File: sv/fifo_queue_with_delete_assert.svh
// assertion macros used by the port checker file
`ifndef FIFO_QUEUE_WITH_DELETE_ASSERT_SVH
`define FIFO_QUEUE_WITH_DELETE_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define FQD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fqd assertion failed");

// next-cycle implication, sampled on the rising clock edge, off during reset
`define FQD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fqd assertion failed");

`endif

// File: sv/fqd_pkg.sv
// types and constants of the fifo queue with delete
package fqd_pkg;

    localparam int DEPTH     = 16;
    localparam int TAG_WIDTH = 32;
    localparam int ITEM_W    = 32;
    localparam int TAKEN_W   = 32;
    localparam int LEN_W     = 5;
    localparam int CNT_W     = $clog2(DEPTH + 1);

    localparam int CQ_DEPTH  = 2;
    localparam int CQ_PTR_W  = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W  = $clog2(CQ_DEPTH + 1);

    localparam logic [1:0] CMD_ENQ = 2'd0;
    localparam logic [1:0] CMD_DEQ = 2'd1;
    localparam logic [1:0] CMD_DEL = 2'd2;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    typedef logic [TAG_WIDTH-1:0] tag_t;

    typedef enum logic [1:0] {
        OP_ENQ,
        OP_DEQ,
        OP_DEL,
        OP_REJ
    } op_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [ITEM_W-1:0] item;
    } req_t;

    typedef struct packed {
        logic               status;
        logic [TAKEN_W-1:0] taken;
        logic [LEN_W-1:0]   length;
    } rsp_t;

    typedef struct packed {
        op_t  op;
        tag_t tag;
    } op_req_t;

endpackage

// File: sv/fqd_front.sv
// front end: takes request transactions and classifies them into operations
module fqd_front
    import fqd_pkg::*;
(
    input  logic    req_valid,
    output logic    req_stall,
    input  req_t    req,
    input  logic    full,
    output logic    push,
    output op_req_t push_data
);

    tag_t tag;

    always_comb
    begin
        tag            = TAG_WIDTH'(req.item);
        push_data.tag  = tag;
        unique case (req.cmd)
            CMD_ENQ: push_data.op = (tag != '0) ? OP_ENQ : OP_REJ;
            CMD_DEQ: push_data.op = OP_DEQ;
            CMD_DEL: push_data.op = (tag != '0) ? OP_DEL : OP_REJ;
            default: push_data.op = OP_REJ;
        endcase
    end

    assign req_stall = full;
    assign push      = req_valid && !full;

endmodule

// File: sv/fqd_cmd_queue.sv
// short queue of classified operations between front and back
module fqd_cmd_queue
    import fqd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  op_req_t push_data,
    output logic    full,
    input  logic    pop,
    output logic    head_valid,
    output op_req_t head
);

    op_req_t               q_reg [CQ_DEPTH];
    logic [CQ_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [CQ_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CQ_CNT_W-1:0]   fill_reg, fill_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full       = (fill_reg == CQ_CNT_W'(CQ_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head       = q_reg[rd_ptr_reg];

endmodule

// File: sv/fqd_back.sv
// back end: shift-register queue with a comparator per cell and the result register
module fqd_back
    import fqd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    head_valid,
    input  op_req_t head,
    output logic    pop,
    output logic    rsp_valid,
    input  logic    rsp_stall,
    output rsp_t    rsp
);

    tag_t             cell_reg [DEPTH];
    logic [CNT_W-1:0] count_reg, count_next;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg, rsp_next;

    logic             exec;
    logic [DEPTH-1:0] hit;
    logic [DEPTH-1:0] del_mask;
    logic [DEPTH-1:0] shift_mask;
    logic             do_enq;
    logic             do_shift;

    assign exec = head_valid && (!rsp_valid_reg || !rsp_stall);
    assign pop  = exec;

    // per-cell compare, then prefix or so every cell from the first hit on shifts
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            hit[i] = (CNT_W'(i) < count_reg) && (cell_reg[i] == head.tag);
        end
        del_mask[0] = hit[0];
        for (int i = 1; i < DEPTH; i++)
        begin
            del_mask[i] = del_mask[i-1] | hit[i];
        end
    end

    always_comb
    begin
        do_enq          = 1'b0;
        do_shift        = 1'b0;
        shift_mask      = del_mask;
        count_next      = count_reg;
        rsp_next.status = ST_ERR;
        rsp_next.taken  = '0;
        unique case (head.op)
            OP_ENQ:
            begin
                if (count_reg != CNT_W'(DEPTH))
                begin
                    do_enq          = 1'b1;
                    count_next      = count_reg + 1'b1;
                    rsp_next.status = ST_OK;
                end
            end
            OP_DEQ:
            begin
                if (count_reg != '0)
                begin
                    do_shift        = 1'b1;
                    shift_mask      = '1;
                    count_next      = count_reg - 1'b1;
                    rsp_next.status = ST_OK;
                    rsp_next.taken  = TAKEN_W'(cell_reg[0]);
                end
            end
            OP_DEL:
            begin
                if (del_mask[DEPTH-1])
                begin
                    do_shift        = 1'b1;
                    count_next      = count_reg - 1'b1;
                    rsp_next.status = ST_OK;
                end
            end
            default:
            begin
                rsp_next.status = ST_ERR;
            end
        endcase
        rsp_next.length = LEN_W'(count_next);
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        always_ff @(posedge clk)
        begin
            if (exec && do_enq && (CNT_W'(g) == count_reg))
            begin
                cell_reg[g] <= head.tag;
            end
            else if (exec && do_shift && shift_mask[g])
            begin
                if (g < DEPTH - 1)
                begin
                    cell_reg[g] <= cell_reg[(g < DEPTH - 1) ? g + 1 : g];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (exec)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: sv/fifo_queue_with_delete.sv
// top level of the fifo queue with delete by value
//
//   channel  dir  handshake              payload
//   req      in   req_valid / req_stall  req_t: cmd, item
//   rsp      out  rsp_valid / rsp_stall  rsp_t: status, taken, length
//
// one request transaction per cycle sustained while rsp_stall is low; every
// command runs in the back end, which shifts the affected cells at once
// each request passes the operation queue, then the result register
// req_stall rises only when the two-entry operation queue is full, which
// happens when rsp_stall holds the result register
// reset clears the queue length and all control; cell contents are not reset
module fifo_queue_with_delete
    import fqd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic    full;
    logic    push;
    op_req_t push_data;
    logic    pop;
    logic    head_valid;
    op_req_t head;

    fqd_front u_front (
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    fqd_cmd_queue u_cmd_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    fqd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp)
    );

endmodule

// File: sv/fqd_checker.sv
// port checker for the fifo queue with delete, bound to the top level
`include "fifo_queue_with_delete_assert.svh"

module fqd_port_checker
    import fqd_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    logic [LEN_W-1:0] last_len_reg;
    logic             rsp_take;
    logic             err_take;

    assign rsp_take = rsp_valid && !rsp_stall;
    assign err_take = rsp_take && (rsp.status == ST_ERR);

    // length reported by the last response transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_len_reg <= '0;
        end
        else if (rsp_take)
        begin
            last_len_reg <= rsp.length;
        end
    end

    `FQD_ASSERT_NEXT(a_req_hold, clk, rst_n, req_valid && req_stall, req_valid && $stable(req))
    `FQD_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
    `FQD_ASSERT_NOW(a_len_bound, clk, rst_n, rsp_valid, rsp.length <= LEN_W'(DEPTH))
    `FQD_ASSERT_NOW(a_taken_ok, clk, rst_n, rsp_valid && (rsp.taken != '0), rsp.status == ST_OK)
    `FQD_ASSERT_NOW(a_err_keeps_len, clk, rst_n, err_take, rsp.length == last_len_reg)

endmodule

bind fifo_queue_with_delete fqd_port_checker u_fqd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

// File: verif/fqd_checker.sv
// checker for the fifo queue with delete: tracks held tags and compares responses
`timescale 1ns / 100ps

module fqd_checker
    import fqd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_stall,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_stall,
    input  rsp_t rsp,
    output int   errors,
    output int   pending
);

    tag_t held_tags[$];
    rsp_t due_rsps[$];
    int   err_cnt;

    // applies one command to the held tags and returns the response it must give
    function automatic rsp_t run_command(input req_t r);
        rsp_t res;
        int   hit;
        res = '{status: ST_ERR, taken: '0, length: '0};
        hit = -1;
        case (r.cmd)
            CMD_ENQ:
            begin
                if (r.item != '0 && held_tags.size() < DEPTH)
                begin
                    held_tags.push_back(tag_t'(r.item));
                    res.status = ST_OK;
                end
            end
            CMD_DEQ:
            begin
                if (held_tags.size() != 0)
                begin
                    res.taken  = TAKEN_W'(held_tags.pop_front());
                    res.status = ST_OK;
                end
            end
            CMD_DEL:
            begin
                if (r.item != '0)
                begin
                    // only the match nearest the head goes
                    for (int i = 0; i < held_tags.size(); i++)
                        if (hit < 0 && held_tags[i] == tag_t'(r.item))
                            hit = i;
                    if (hit >= 0)
                    begin
                        held_tags.delete(hit);
                        res.status = ST_OK;
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.length = LEN_W'(held_tags.size());
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_t want;
        if (!rst_n)
        begin
            held_tags.delete();
            due_rsps.delete();
            err_cnt = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (due_rsps.size() == 0)
                begin
                    $error("unexpected response transaction: status %0d taken %h length %0d",
                           rsp.status, rsp.taken, rsp.length);
                    err_cnt++;
                end
                else
                begin
                    want = due_rsps.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, rsp.status);
                        err_cnt++;
                    end
                    if (rsp.taken !== want.taken)
                    begin
                        $error("taken: expected %h, actual %h", want.taken, rsp.taken);
                        err_cnt++;
                    end
                    if (rsp.length !== want.length)
                    begin
                        $error("length: expected %0d, actual %0d", want.length, rsp.length);
                        err_cnt++;
                    end
                end
            end
            if (req_valid && !req_stall)
                due_rsps.push_back(run_command(req));
            errors  <= err_cnt;
            pending <= due_rsps.size();
        end
    end

endmodule

// File: verif/tb_fifo_queue_with_delete.sv
// testbench top for the fifo queue with delete: stimulus, idling and verdict
`timescale 1ns / 100ps

module tb_fifo_queue_with_delete;
    import fqd_pkg::*;

    // command code with no operation behind it
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 1400;
    localparam int LONG_HOLD    = 80;
    localparam int CYCLE_LIMIT  = 200000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    req_t req       = '0;
    logic rsp_stall = 1'b0;
    logic req_stall;
    logic rsp_valid;
    rsp_t rsp;

    int errors;
    int pending;
    int cycle_cnt = 0;
    bit gaps_on   = 1'b1;
    bit hold_off  = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    fifo_queue_with_delete DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    fqd_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .errors    (errors),
        .pending   (pending)
    );

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // offers one request transaction until accepted, then may idle for a gap
    task automatic issue(input logic [1:0] c, input tag_t t);
        req_valid <= 1'b1;
        req       <= '{cmd: c, item: t};
        do
            @(posedge clk);
        while (req_stall);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    // small tags dominate so deletes find matches and duplicates occur
    function automatic tag_t pick_tag();
        case ($urandom_range(0, 19))
            0:       return '0;
            1, 2:    return tag_t'($urandom());
            3:       return '1;
            default: return tag_t'($urandom_range(1, 24));
        endcase
    endfunction

    function automatic logic [1:0] pick_cmd(input int enq_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return CMD_UNUSED;
        if (r < enq_pct)
            return CMD_ENQ;
        if (r < enq_pct + (100 - enq_pct) / 2)
            return CMD_DEQ;
        return CMD_DEL;
    endfunction

    // response side: random stall bursts, plus one long hold on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                hold_off = 1'b0;
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    initial
    begin : stimulus
        int n;
        int enq_pct;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // null tag, empty queue and unused code cases
        issue(CMD_ENQ, '0);
        issue(CMD_DEQ, '1);
        issue(CMD_DEL, 32'd5);
        issue(CMD_UNUSED, 32'd7);
        issue(CMD_DEL, '0);
        // extreme tags, duplicate tag, first match goes, no match
        issue(CMD_ENQ, '1);
        issue(CMD_ENQ, 32'd1);
        issue(CMD_ENQ, 32'h8000_0000);
        issue(CMD_ENQ, 32'd1);
        issue(CMD_DEL, 32'd1);
        issue(CMD_DEL, 32'h0001_2345);
        issue(CMD_DEQ, 32'hA5A5_5A5A);
        // fill up, overflow, then delete at the tail
        for (n = 0; n < 14; n++)
            issue(CMD_ENQ, tag_t'(n + 2));
        issue(CMD_ENQ, 32'd99);
        issue(CMD_DEL, 32'd15);

        enq_pct = 50;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
                enq_pct = $urandom_range(25, 70);
            if (n == 500)
                hold_off = 1'b1;
            if (n == 900)
            begin
                // let all outstanding responses drain before going on
                req_valid <= 1'b0;
                @(posedge clk);
                wait (pending == 0);
                @(posedge clk);
            end
            if (n == RANDOM_ITEMS - 200)
                gaps_on = 1'b0;
            issue(pick_cmd(enq_pct), pick_tag());
        end
        req_valid <= 1'b0;

        @(posedge clk);
        wait (pending == 0);
        repeat (6) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/fqd_pkg.sv
sv/fqd_front.sv
sv/fqd_cmd_queue.sv
sv/fqd_back.sv
sv/fifo_queue_with_delete.sv
sv/fqd_checker.sv
verif/fqd_checker.sv
verif/tb_fifo_queue_with_delete.sv
